@@ hdl/tqla_pkg.sv @@
// ----------------------------------------------------------------------------
// tqla_pkg
// Shared types and constants of the tabular Q-learning agent core.
// ----------------------------------------------------------------------------
package tqla_pkg;

    // Sequencer states of the agent core.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_SCAN,
        ST_QREAD,
        ST_MUL1,
        ST_TD,
        ST_MUL2,
        ST_WB,
        ST_SEL
    } t_state;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NUM_ACTIONS  = 3'd0;
    localparam logic [2:0] CFG_ARENA_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_ARENA_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_LEARN_RATE   = 3'd3;
    localparam logic [2:0] CFG_DISCOUNT     = 3'd4;
    localparam logic [2:0] CFG_EXPLORE_RATE = 3'd5;

    // Field widths.
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 17;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int ACT_W   = 3;
    localparam int VAL_W   = 32;
    localparam int FRAC_W  = 16;

    // Register reset values.
    localparam logic [3:0]        RST_NUM_ACTIONS  = 4'd8;
    localparam logic [SIZE_W-1:0] RST_ARENA_WIDTH  = 15'd800;
    localparam logic [SIZE_W-1:0] RST_ARENA_HEIGHT = 15'd600;
    localparam logic [CFG_DW-1:0] RST_LEARN_RATE   = 17'd6554;
    localparam logic [CFG_DW-1:0] RST_DISCOUNT     = 17'd62259;
    localparam logic [CFG_DW-1:0] RST_EXPLORE_RATE = 17'd6554;

endpackage

@@ hdl/tabular_q_learning_agent_core.sv @@
// ----------------------------------------------------------------------------
// tabular_q_learning_agent_core
// Tabular Q-learning agent with epsilon-greedy action choice and one
// synchronous value memory.
// ----------------------------------------------------------------------------
// After reset the core sweeps the whole value table to zero, one word per
// cycle (BUCKETS**4 * MAX_ACTIONS words, 80000 at the defaults), and holds
// busy high meanwhile. An item is taken when start is high and busy is low;
// busy then stays high until the single result strobe. Each coordinate is
// bucketized by a shared restoring divider, a load step followed by one
// division step per quotient bit (four coordinates for a select, eight for an
// update). A greedy select then reads its row through the memory port and
// picks the action in ST_SEL; an exploring select skips the row read. An
// update reads the next row, reads the old value, runs the MUL1, TD and MUL2
// arithmetic states and writes the result back in WB. The result is shown for
// exactly one cycle on o_valid; there is no stall.
module tabular_q_learning_agent_core #(
    parameter int BUCKETS     = 10,
    parameter int MAX_ACTIONS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [tqla_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [tqla_pkg::CFG_DW-1:0]   i_cfg_data,
    // Command
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic signed [15:0]            i_robot_x,
    input  logic signed [15:0]            i_robot_y,
    input  logic signed [15:0]            i_target_x,
    input  logic signed [15:0]            i_target_y,
    input  logic signed [15:0]            i_next_robot_x,
    input  logic signed [15:0]            i_next_robot_y,
    input  logic signed [15:0]            i_next_target_x,
    input  logic signed [15:0]            i_next_target_y,
    input  logic [2:0]                    i_taken_action,
    input  logic signed [31:0]            i_reward,
    input  logic [31:0]                   i_random_word,
    // Result
    output logic                          o_valid,
    output logic [2:0]                    o_chosen_action,
    output logic                          o_explored,
    output logic signed [31:0]            o_new_value
);
    import tqla_pkg::*;

    localparam int ROWS  = BUCKETS ** 4;
    localparam int DEPTH = ROWS * MAX_ACTIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(ROWS);
    localparam int BW    = $clog2(BUCKETS);
    localparam int QW    = $clog2(BUCKETS + 1);
    localparam int SPW   = (QW > 1) ? $clog2(QW) : 1;
    localparam int NUMW  = SIZE_W + QW;
    localparam int NW    = $clog2(MAX_ACTIONS + 1);
    localparam int IW    = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int GPW   = 50;
    localparam int TDW   = 36;
    localparam int PW    = 54;
    localparam int NVW   = 39;

    // Configuration registers
    logic [3:0]        r_num_actions;
    logic [SIZE_W-1:0] r_arena_width;
    logic [SIZE_W-1:0] r_arena_height;
    logic [CFG_DW-1:0] r_learn_rate;
    logic [CFG_DW-1:0] r_discount;
    logic [CFG_DW-1:0] r_explore_rate;

    // Sequencer and item registers
    t_state                    r_state, n_state;
    logic [AW-1:0]             r_clr_addr;
    logic                      r_action;
    logic signed [COORD_W-1:0] r_coords [8];
    logic [ACT_W-1:0]          r_taken;
    logic signed [VAL_W-1:0]   r_reward;
    logic [31:0]               r_rand;
    logic [2:0]                r_k;
    logic [SPW-1:0]            r_step;
    logic [NUMW-1:0]           r_rem;
    logic [SIZE_W-1:0]         r_dvs;
    logic [QW-1:0]             r_quo;
    logic [SW-1:0]             r_row_cur;
    logic [SW-1:0]             r_row_nxt;
    logic [NW-1:0]             r_idx;
    logic                      r_rd_vld;
    logic [IW-1:0]             r_rd_act;
    logic signed [VAL_W-1:0]   r_best;
    logic [IW-1:0]             r_best_act;
    logic signed [VAL_W-1:0]   r_q;
    logic signed [GPW-1:0]     r_gprod;
    logic signed [TDW-1:0]     r_td;
    logic signed [PW-1:0]      r_prod;
    logic                      r_out_valid;
    logic [ACT_W-1:0]          r_out_act;
    logic                      r_out_expl;
    logic signed [VAL_W-1:0]   r_out_val;

    // Value memory
    logic signed [VAL_W-1:0]   r_mem [DEPTH];
    logic signed [VAL_W-1:0]   r_rd_data;

    logic                      w_accept;
    logic                      w_mem_we;
    logic [AW-1:0]             w_mem_waddr;
    logic signed [VAL_W-1:0]   w_mem_wdata;
    logic                      w_mem_re;
    logic [AW-1:0]             w_mem_raddr;
    logic                      w_issue;
    logic [NW-1:0]             w_n;
    logic [IW-1:0]             w_taken_sat;
    logic                      w_explore;
    logic [ACT_W-1:0]          w_pick;
    logic [SIZE_W-1:0]         w_size;
    logic [SIZE_W-1:0]         w_clamp;
    logic [NUMW:0]             w_trial;
    logic [QW-1:0]             w_quo;
    logic [BW-1:0]             w_bucket;
    logic                      w_div_last;
    logic                      w_coords_done;
    logic [SW-1:0]             w_row_scan;
    logic signed [NVW-1:0]     w_nv;
    logic signed [VAL_W-1:0]   w_nv_sat;
    logic [NW+15:0]            w_pick_prod;

    assign w_accept = start && !busy;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_actions  <= RST_NUM_ACTIONS;
            r_arena_width  <= RST_ARENA_WIDTH;
            r_arena_height <= RST_ARENA_HEIGHT;
            r_learn_rate   <= RST_LEARN_RATE;
            r_discount     <= RST_DISCOUNT;
            r_explore_rate <= RST_EXPLORE_RATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_NUM_ACTIONS:  r_num_actions  <= i_cfg_data[3:0];
                CFG_ARENA_WIDTH:  r_arena_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_ARENA_HEIGHT: r_arena_height <= i_cfg_data[SIZE_W-1:0];
                CFG_LEARN_RATE:   r_learn_rate   <= i_cfg_data;
                CFG_DISCOUNT:     r_discount     <= i_cfg_data;
                CFG_EXPLORE_RATE: r_explore_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective action count and saturated taken action.
    always_comb begin
        if (r_num_actions == 4'd0) begin
            w_n = NW'(1);
        end else if (5'({1'b0, r_num_actions}) > 5'(MAX_ACTIONS)) begin
            w_n = NW'(MAX_ACTIONS);
        end else begin
            w_n = NW'(r_num_actions);
        end
        if (5'(r_taken) >= 5'(w_n)) begin
            w_taken_sat = IW'(w_n - NW'(1));
        end else begin
            w_taken_sat = IW'(r_taken);
        end
    end

    // Exploration test and random pick.
    assign w_explore   = 17'(r_rand[15:0]) < r_explore_rate;
    assign w_pick_prod = (NW + 16)'(r_rand[31:16]) * (NW + 16)'(w_n);
    assign w_pick      = ACT_W'(w_pick_prod[NW+15:16]);

    // Coordinate clamp; even coordinates are x, odd ones are y.
    always_comb begin
        w_size = r_k[0] ? r_arena_height : r_arena_width;
        if (w_size == '0) begin
            w_size = SIZE_W'(1);
        end
        if (r_coords[r_k][COORD_W-1]) begin
            w_clamp = '0;
        end else if (r_coords[r_k][SIZE_W-1:0] > w_size) begin
            w_clamp = w_size;
        end else begin
            w_clamp = r_coords[r_k][SIZE_W-1:0];
        end
    end

    // One restoring division step and the capped bucket.
    always_comb begin
        w_trial = {1'b0, r_rem} - ((NUMW + 1)'(r_dvs) << r_step);
        w_quo   = r_quo;
        if (!w_trial[NUMW]) begin
            w_quo[r_step] = 1'b1;
        end
        if (w_quo >= QW'(BUCKETS)) begin
            w_bucket = BW'(BUCKETS - 1);
        end else begin
            w_bucket = BW'(w_quo);
        end
    end

    assign w_div_last    = (r_step == '0);
    assign w_coords_done = (r_k == 3'd7) || (r_k == 3'd3 && !r_action);
    assign w_row_scan    = r_action ? r_row_nxt : r_row_cur;
    assign w_issue       = (r_state == ST_SCAN) && (r_idx < w_n);

    // New value with saturation to 32 bits.
    always_comb begin
        w_nv = NVW'(r_q) + NVW'(r_prod >>> FRAC_W);
        if (w_nv[NVW-1:VAL_W-1] == '0 || w_nv[NVW-1:VAL_W-1] == '1) begin
            w_nv_sat = w_nv[VAL_W-1:0];
        end else if (w_nv[NVW-1]) begin
            w_nv_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            w_nv_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (start) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_last) begin
                    if (!w_coords_done) begin
                        n_state = ST_LOAD;
                    end else if (!r_action && w_explore) begin
                        n_state = ST_SEL;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx == w_n && !r_rd_vld) begin
                    n_state = r_action ? ST_QREAD : ST_SEL;
                end
            end
            ST_QREAD: n_state = ST_MUL1;
            ST_MUL1:  n_state = ST_TD;
            ST_TD:    n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_WB;
            ST_WB:    n_state = ST_IDLE;
            ST_SEL:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Memory port controls and busy.
    always_comb begin
        busy        = (r_state != ST_IDLE);
        w_mem_we    = 1'b0;
        w_mem_waddr = r_clr_addr;
        w_mem_wdata = '0;
        w_mem_re    = 1'b0;
        w_mem_raddr = AW'(w_row_scan) * AW'(MAX_ACTIONS) + AW'(r_idx);
        unique case (r_state)
            ST_CLEAR: w_mem_we = 1'b1;
            ST_SCAN:  w_mem_re = w_issue;
            ST_QREAD: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = AW'(r_row_cur) * AW'(MAX_ACTIONS) + AW'(w_taken_sat);
            end
            ST_WB: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = AW'(r_row_cur) * AW'(MAX_ACTIONS) + AW'(w_taken_sat);
                w_mem_wdata = w_nv_sat;
            end
            default: ;
        endcase
    end

    // Value memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_mem_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= w_issue;
            r_out_valid <= (r_state == ST_WB) || (r_state == ST_SEL);
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Item datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_action    <= i_action;
                    r_coords[0] <= i_robot_x;
                    r_coords[1] <= i_robot_y;
                    r_coords[2] <= i_target_x;
                    r_coords[3] <= i_target_y;
                    r_coords[4] <= i_next_robot_x;
                    r_coords[5] <= i_next_robot_y;
                    r_coords[6] <= i_next_target_x;
                    r_coords[7] <= i_next_target_y;
                    r_taken     <= i_taken_action;
                    r_reward    <= i_reward;
                    r_rand      <= i_random_word;
                    r_k         <= 3'd0;
                    r_row_cur   <= '0;
                    r_row_nxt   <= '0;
                end
            end
            ST_LOAD: begin
                r_rem  <= NUMW'(w_clamp) * NUMW'(BUCKETS);
                r_dvs  <= w_size;
                r_quo  <= '0;
                r_step <= SPW'(QW - 1);
            end
            ST_DIV: begin
                if (!w_trial[NUMW]) begin
                    r_rem <= w_trial[NUMW-1:0];
                end
                r_quo  <= w_quo;
                r_step <= r_step - SPW'(1);
                if (w_div_last) begin
                    // Fold the bucket into the row index of its state.
                    if (r_k[2]) begin
                        r_row_nxt <= r_row_nxt * SW'(BUCKETS) + SW'(w_bucket);
                    end else begin
                        r_row_cur <= r_row_cur * SW'(BUCKETS) + SW'(w_bucket);
                    end
                    r_k   <= r_k + 3'd1;
                    r_idx <= '0;
                end
            end
            ST_SCAN: begin
                if (w_issue) begin
                    r_idx    <= r_idx + NW'(1);
                    r_rd_act <= r_idx[IW-1:0];
                end
                // The first maximum wins, so only a strictly larger value replaces it.
                if (r_rd_vld) begin
                    if (r_rd_act == '0 || r_rd_data > r_best) begin
                        r_best     <= r_rd_data;
                        r_best_act <= r_rd_act;
                    end
                end
            end
            ST_MUL1: begin
                r_q     <= r_rd_data;
                r_gprod <= GPW'($signed({1'b0, r_discount})) * GPW'(r_best);
            end
            ST_TD: begin
                r_td <= TDW'(r_reward) + TDW'(r_gprod >>> FRAC_W) - TDW'(r_q);
            end
            ST_MUL2: begin
                r_prod <= PW'($signed({1'b0, r_learn_rate})) * PW'(r_td);
            end
            ST_WB: begin
                r_out_act  <= '0;
                r_out_expl <= 1'b0;
                r_out_val  <= w_nv_sat;
            end
            ST_SEL: begin
                r_out_act  <= w_explore ? w_pick : ACT_W'(r_best_act);
                r_out_expl <= w_explore;
                r_out_val  <= '0;
            end
            default: ;
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_chosen_action = r_out_act;
    assign o_explored      = r_out_expl;
    assign o_new_value     = r_out_val;

    // Checks on the sequencer.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !w_mem_we)
        else $error("value memory written while idle");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_SCAN))
        else $error("row read data arrived outside the scan");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_explored && (o_new_value != '0)))
        else $error("explored select carried an updated value");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tabular Q-learning agent core. Select and update
// commands are driven over several register settings. An in-bench value table
// and scaling arithmetic predict every result, which is then compared field by
// field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import tqla_pkg::*;

    localparam int NB         = 10;
    localparam int NACT       = 8;
    localparam int DEPTH      = NB * NB * NB * NB * NACT;
    localparam int IDLE_LIMIT = 300000;
    localparam int PER_PHASE  = 330;

    typedef struct {
        logic               op;
        logic signed [15:0] cur [4];
        logic signed [15:0] nxt [4];
        logic [2:0]         taken;
        logic signed [31:0] reward;
        logic [31:0]        rword;
    } t_command;

    typedef struct {
        logic [2:0]         act;
        logic               expl;
        logic signed [31:0] value;
    } t_outcome;

    // Agent model: value table, register copies and the queue of pending outcomes.
    class agent_scoreboard;
        int        qval [DEPTH];
        int        n_act, width, height, alpha, gamma, eps;
        t_outcome  pending [$];
        int        mismatches;

        function void init();
            foreach (qval[k]) qval[k] = 0;
            n_act = int'(RST_NUM_ACTIONS);
            width = int'(RST_ARENA_WIDTH);
            height = int'(RST_ARENA_HEIGHT);
            alpha = int'(RST_LEARN_RATE);
            gamma = int'(RST_DISCOUNT);
            eps = int'(RST_EXPLORE_RATE);
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [16:0] data);
            case (idx)
                CFG_NUM_ACTIONS:  n_act  = int'(data[3:0]);
                CFG_ARENA_WIDTH:  width  = int'(data[14:0]);
                CFG_ARENA_HEIGHT: height = int'(data[14:0]);
                CFG_LEARN_RATE:   alpha  = int'(data);
                CFG_DISCOUNT:     gamma  = int'(data);
                CFG_EXPLORE_RATE: eps    = int'(data);
                default: ;
            endcase
        endfunction

        function int bucket(logic signed [15:0] v, int size);
            int s, c, b;
            s = (size == 0) ? 1 : size;
            c = (v < 0) ? 0 : ((int'(v) > s) ? s : int'(v));
            b = c * NB / s;
            return (b >= NB) ? NB - 1 : b;
        endfunction

        function int row(logic signed [15:0] c [4]);
            return ((((bucket(c[0], width) * NB + bucket(c[1], height)) * NB
                    + bucket(c[2], width)) * NB + bucket(c[3], height)) * NACT);
        endfunction

        // Work out the outcome of one accepted command and apply its table write.
        function void note(t_command cmd);
            t_outcome o;
            int n, base, nbase, a, best;
            longint td, nv;
            n = (n_act == 0) ? 1 : ((n_act > NACT) ? NACT : n_act);
            base = row(cmd.cur);
            o = '{3'd0, 1'b0, 32'sd0};
            if (!cmd.op) begin
                if (int'(cmd.rword[15:0]) < eps) begin
                    o.expl = 1'b1;
                    o.act  = 3'((int'(cmd.rword[31:16]) * n) >> 16);
                end else begin
                    a = 0;
                    for (int k = 1; k < n; k++)
                        if (qval[base + k] > qval[base + a]) a = k;
                    o.act = 3'(a);
                end
            end else begin
                nbase = row(cmd.nxt);
                a = (int'(cmd.taken) >= n) ? n - 1 : int'(cmd.taken);
                best = qval[nbase];
                for (int k = 1; k < n; k++)
                    if (qval[nbase + k] > best) best = qval[nbase + k];
                td = longint'(cmd.reward) + ((longint'(gamma) * best) >>> 16)
                     - longint'(qval[base + a]);
                nv = longint'(qval[base + a]) + ((longint'(alpha) * td) >>> 16);
                if (nv > 64'sd2147483647) nv = 64'sd2147483647;
                if (nv < -64'sd2147483648) nv = -64'sd2147483648;
                qval[base + a] = int'(nv);
                o.value = int'(nv);
            end
            pending.push_back(o);
        endfunction

        function void check(logic [2:0] act, logic expl, logic signed [31:0] value);
            t_outcome e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: act=%0d expl=%0b value=%0d",
                             act, expl, value);
                return;
            end
            e = pending.pop_front();
            if (act !== e.act || expl !== e.expl || value !== e.value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected act=%0d expl=%0b value=%0d,",
                              " got act=%0d expl=%0b value=%0d"},
                             e.act, e.expl, e.value, act, expl, value);
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n;
    logic               i_cfg_we;
    logic [CFG_AW-1:0]  i_cfg_addr;
    logic [CFG_DW-1:0]  i_cfg_data;
    logic               start, busy;
    logic               i_action;
    logic signed [15:0] i_robot_x, i_robot_y, i_target_x, i_target_y;
    logic signed [15:0] i_next_robot_x, i_next_robot_y, i_next_target_x, i_next_target_y;
    logic [2:0]         i_taken_action;
    logic signed [31:0] i_reward;
    logic [31:0]        i_random_word;
    logic               o_valid;
    logic [2:0]         o_chosen_action;
    logic               o_explored;
    logic signed [31:0] o_new_value;

    agent_scoreboard    board;
    int                 idle_cycles;
    int                 sent;
    logic signed [15:0] spots [6][4];

    tabular_q_learning_agent_core i_dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result checking and the stall watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check(o_chosen_action, o_explored, o_new_value);
        if (i_rst_n && ((start && !busy) || o_valid)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Drive one command and hold it until the transfer takes place.
    task automatic issue(t_command cmd);
        @(negedge i_clk);
        start = 1'b1; i_action = cmd.op;
        {i_robot_x, i_robot_y, i_target_x, i_target_y} =
            {cmd.cur[0], cmd.cur[1], cmd.cur[2], cmd.cur[3]};
        {i_next_robot_x, i_next_robot_y, i_next_target_x, i_next_target_y} =
            {cmd.nxt[0], cmd.nxt[1], cmd.nxt[2], cmd.nxt[3]};
        i_taken_action = cmd.taken; i_reward = cmd.reward; i_random_word = cmd.rword;
        do @(posedge i_clk); while (busy);
        board.note(cmd);
        sent++;
        // Random idle gaps once the core is ready again, except over one long stretch.
        if ((sent < 600 || sent > 900) && $urandom_range(99) < 17) begin
            @(negedge i_clk);
            start = 1'b0;
            while (busy) @(negedge i_clk);
            repeat ($urandom_range(6)) @(negedge i_clk);
        end
    endtask

    // Register writes happen only once the core is idle and nothing is pending.
    task automatic write_reg(logic [2:0] idx, logic [16:0] data);
        @(negedge i_clk);
        start = 1'b0;
        while (board.pending.size() != 0 || busy) @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_addr = idx; i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.write_reg(idx, data);
    endtask

    function automatic logic signed [15:0] coord(int size);
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(size + 10) - 5);
        endcase
    endfunction

    function automatic t_command random_command();
        t_command c;
        int p, q;
        p = $urandom_range(5);
        q = ($urandom_range(3) == 0) ? p : $urandom_range(5);
        c.op = 1'($urandom_range(1));
        for (int k = 0; k < 4; k++) begin
            c.cur[k] = ($urandom_range(9) < 8) ? spots[p][k]
                     : coord((k % 2) ? board.height : board.width);
            c.nxt[k] = ($urandom_range(9) < 8) ? spots[q][k]
                     : coord((k % 2) ? board.height : board.width);
        end
        c.taken = 3'($urandom_range(7));
        case ($urandom_range(9))
            0:       c.reward = $urandom;
            1:       c.reward = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: c.reward = $signed($urandom_range(1048576)) - 524288;
        endcase
        c.rword = $urandom;
        return c;
    endfunction

    initial begin
        t_command c;
        int cfg [6][6] = '{
            '{3, 1000, 1000, 32768, 65536, 0},
            '{0, 0, 1, 65536, 131071, 65536},
            '{15, 32767, 32767, 131071, 0, 131071},
            '{8, 50, 20, 1, 32768, 20000},
            '{5, 800, 600, 6554, 62259, 6554},
            '{2, 1, 32767, 100000, 65535, 32768}
        };
        board = new();
        board.init();
        idle_cycles = 0; sent = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_addr = '0; i_cfg_data = '0;
        start = 1'b0; i_action = 1'b0;
        {i_robot_x, i_robot_y, i_target_x, i_target_y} = '0;
        {i_next_robot_x, i_next_robot_y, i_next_target_x, i_next_target_y} = '0;
        i_taken_action = '0; i_reward = '0; i_random_word = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: coordinate extremes, reward limits, explore edges, same-state update.
        for (int d = 0; d < 16; d++) begin
            c.op = d[0];
            for (int k = 0; k < 4; k++) begin
                c.cur[k] = (d < 4) ? 16'sh8000 : ((d < 8) ? 16'sh7FFF : 16'sd400);
                c.nxt[k] = (d < 12) ? c.cur[k] : 16'sd0;
            end
            c.taken = (d % 3 == 0) ? 3'd7 : 3'(d);
            c.reward = (d % 4 == 1) ? 32'sh7FFFFFFF
                     : ((d % 4 == 3) ? 32'sh80000000 : 32'sd65536);
            c.rword = (d % 4 == 0) ? 32'hFFFFFFFF : ((d % 4 == 2) ? 32'h0000FFFF : 32'h0);
            issue(c);
        end
        write_reg(3'd7, 17'h1FFFF);

        // Random phases, one per register setting.
        for (int ph = 0; ph < 6; ph++) begin
            for (int r = 0; r < 6; r++) write_reg(3'(r), 17'(cfg[ph][r]));
            for (int s = 0; s < 6; s++)
                for (int k = 0; k < 4; k++)
                    spots[s][k] = 16'($urandom_range((k % 2) ? board.height : board.width));
            for (int it = 0; it < PER_PHASE; it++) issue(random_command());
        end

        @(negedge i_clk);
        start = 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
